// File: hw/rtl/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
package tccw_pkg;

   localparam logic [15:0] LINE_BYTES   = 16'd160;
   localparam logic [7:0]  VISIBLE_ROWS = 8'd25;
   localparam logic [7:0]  ROW_MAX      = 8'd255;
   localparam logic [7:0]  NEWLINE_CHAR = 8'd10;
   localparam logic [7:0]  RESET_ATTR   = 8'h07;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_MINUS   = 8'h2D;

   localparam int INT_BITS   = 32;
   localparam int DEC_DIGITS = 10;

   localparam logic [1:0] MODE_CHAR = 2'd0;
   localparam logic [1:0] MODE_INT  = 2'd1;
   localparam logic [1:0] MODE_HOME = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         char_value;
      logic signed [31:0] int_value;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_offset;
      logic [7:0]  glyph;
      logic [7:0]  attr_out;
      logic        off_screen;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       put;
      logic       home;
      logic [7:0] glyph;
   } cur_cmd_type;

   typedef struct packed {
      logic        emit;
      logic [15:0] cell_offset;
      logic        off_screen;
   } cur_info_type;

   typedef struct packed {
      logic        start;
      logic        shift;
      logic [31:0] magnitude;
   } bcd_cmd_type;

   typedef struct packed {
      logic       done;
      logic [3:0] top_digit;
   } bcd_stat_type;

endpackage

// File: hw/rtl/tccw_bcd.sv
// Bit-serial binary to BCD converter holding the decimal digits for readout.
module tccw_bcd (
   input  logic                  clock,
   input  logic                  reset,
   input  tccw_pkg::bcd_cmd_type cmd,
   output tccw_pkg::bcd_stat_type stat
);
   import tccw_pkg::*;

   localparam int BCD_BITS = 4 * DEC_DIGITS;

   logic [INT_BITS-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0] bcd_ff, bcd_in, adj;
   logic [5:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;

   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                    : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (cmd.start) begin
         bin_in  = cmd.magnitude;
         bcd_in  = '0;
         cnt_in  = 6'(INT_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in  = {adj[BCD_BITS-2:0], bin_ff[INT_BITS-1]};
         bin_in  = {bin_ff[INT_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - 6'd1;
         busy_in = (cnt_ff != 6'd1);
      end else if (cmd.shift) begin
         bcd_in = {bcd_ff[BCD_BITS-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign stat.done      = !busy_ff;
   assign stat.top_digit = bcd_ff[BCD_BITS-1 -: 4];

endmodule

// File: hw/rtl/tccw_cursor.sv
// Text cursor: lazy wrap, newline, home, and cell offset of the next write.
module tccw_cursor (
   input  logic                   clock,
   input  logic                   reset,
   input  tccw_pkg::cur_cmd_type  cmd,
   output tccw_pkg::cur_info_type info
);
   import tccw_pkg::*;

   logic [7:0] row_ff, row_in;
   logic [7:0] column_ff, column_in;
   logic [7:0] wrap_row, wrap_col;
   logic       wrap;

   assign wrap     = (16'(column_ff) >= LINE_BYTES);
   assign wrap_row = (wrap && row_ff != ROW_MAX) ? row_ff + 8'd1 : row_ff;
   assign wrap_col = wrap ? 8'd0 : column_ff;

   assign info.emit        = (cmd.glyph != NEWLINE_CHAR);
   assign info.cell_offset = 16'(wrap_row) * LINE_BYTES + 16'(wrap_col);
   assign info.off_screen  = (wrap_row >= VISIBLE_ROWS);

   always_comb begin
      row_in    = row_ff;
      column_in = column_ff;
      if (cmd.home) begin
         row_in    = '0;
         column_in = '0;
      end else if (cmd.put) begin
         if (info.emit) begin
            row_in    = wrap_row;
            column_in = wrap_col + 8'd2;
         end else begin
            row_in    = (wrap_row != ROW_MAX) ? wrap_row + 8'd1 : wrap_row;
            column_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         column_ff <= '0;
      end else begin
         row_ff    <= row_in;
         column_ff <= column_in;
      end
   end

`ifndef SYNTHESIS
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      16'(column_ff) <= LINE_BYTES + 16'd1)
      else $error("column beyond line end");
   a_row_monotonic: assert property (@(posedge clock) disable iff (reset)
      !cmd.home |=> row_ff >= $past(row_ff))
      else $error("row moved back without home");
`endif

endmodule

// File: hw/rtl/text_console_cell_writer_unit.sv
// Text console cell writer: a character goes to the put state on acceptance
// and is placed in the result register from there (PUT waits while the
// previous result is not yet taken); a newline also passes the put state
// but gives no result, and a home or unused-mode item is done in idle. A
// nonzero integer runs through a bit-serial binary to BCD converter in the
// conversion state, then the skip state shifts out leading zero digits but
// the last, then a minus sign goes through PUT and each digit through DIGIT
// and PUT; zero goes straight to PUT as a single character. One item is in
// work at a time; the next is accepted once the last character is put.
module text_console_cell_writer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tccw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tccw_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata
);
   import tccw_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_CONV, ST_SKIP, ST_DIGIT, ST_PUT} state_type;

   state_type    state_ff, state_in;
   logic [7:0]   attr_ff, attr_in;
   logic [7:0]   glyph_ff, glyph_in;
   logic         last_ff, last_in;
   logic         more_ff, more_in;
   logic         neg_ff, neg_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   cur_cmd_type  cur_cmd;
   cur_info_type cur_info;
   bcd_cmd_type  bcd_cmd;
   bcd_stat_type bcd_stat;
   logic         accept, slot_free;

   tccw_cursor u_cursor (.clock(clock), .reset(reset), .cmd(cur_cmd), .info(cur_info));
   tccw_bcd    u_bcd    (.clock(clock), .reset(reset), .cmd(bcd_cmd), .stat(bcd_stat));

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      attr_in      = csr_we ? csr_wdata : attr_ff;
      glyph_in     = glyph_ff;
      last_in      = last_ff;
      more_in      = more_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cur_cmd      = '{put: 1'b0, home: 1'b0, glyph: glyph_ff};
      bcd_cmd      = '{start: 1'b0, shift: 1'b0,
                       magnitude: req_data.int_value[31] ? 32'(-req_data.int_value)
                                                         : 32'(req_data.int_value)};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  MODE_CHAR: begin
                     glyph_in = req_data.char_value;
                     last_in  = 1'b1;
                     more_in  = 1'b0;
                     state_in = ST_PUT;
                  end
                  MODE_INT: begin
                     if (req_data.int_value == '0) begin
                        glyph_in = CHAR_ZERO;
                        last_in  = 1'b1;
                        more_in  = 1'b0;
                        state_in = ST_PUT;
                     end else begin
                        bcd_cmd.start = 1'b1;
                        neg_in        = req_data.int_value[31];
                        cnt_in        = 4'(DEC_DIGITS);
                        state_in      = ST_CONV;
                     end
                  end
                  MODE_HOME: cur_cmd.home = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_CONV: begin
            if (bcd_stat.done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (bcd_stat.top_digit == 4'd0 && cnt_ff != 4'd1) begin
               bcd_cmd.shift = 1'b1;
               cnt_in        = cnt_ff - 4'd1;
            end else if (neg_ff) begin
               glyph_in = CHAR_MINUS;
               last_in  = 1'b0;
               more_in  = 1'b1;
               neg_in   = 1'b0;
               state_in = ST_PUT;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            glyph_in      = CHAR_ZERO + 8'(bcd_stat.top_digit);
            last_in       = (cnt_ff == 4'd1);
            more_in       = (cnt_ff != 4'd1);
            bcd_cmd.shift = 1'b1;
            cnt_in        = cnt_ff - 4'd1;
            state_in      = ST_PUT;
         end
         ST_PUT: begin
            if (slot_free) begin
               cur_cmd.put = 1'b1;
               if (cur_info.emit) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.cell_offset = cur_info.cell_offset;
                  rsp_in.glyph       = glyph_ff;
                  rsp_in.attr_out    = attr_ff;
                  rsp_in.off_screen  = cur_info.off_screen;
                  rsp_in.last        = last_ff;
               end
               state_in = more_ff ? ST_DIGIT : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      last_ff  <= last_in;
      more_ff  <= more_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         attr_ff      <= RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_from_put: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PUT))
      else $error("result raised outside put");
   a_conv_busy_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT || state_ff == ST_SKIP) |-> bcd_stat.done)
      else $error("digit readout while converter busy");
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGIT |-> cnt_ff != 4'd0)
      else $error("digit emitted with no digits left");
`endif

endmodule
